// File: src/aes_dec_pkg.sv
// Package with shared constants, types and AES inverse-cipher functions.
`default_nettype none
package aes_dec_pkg;

    localparam int KEY_WORDS_DEF = 60;
    localparam int BLOCK_BYTES   = 16;

    localparam logic [1:0] OP_LOAD_KEY   = 2'd0;
    localparam logic [1:0] OP_LOAD_CHAIN = 2'd1;
    localparam logic [1:0] OP_DECRYPT    = 2'd2;

    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    localparam logic [1:0] CM_ECB  = 2'd0;
    localparam logic [1:0] CM_CBC  = 2'd1;
    localparam logic [1:0] CM_PCBC = 2'd2;

    localparam logic [0:0] CFG_KEY_SIZE = 1'b0;
    localparam logic [0:0] CFG_CHAIN    = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;     // load ciphertext into the state and ciphertext registers
        logic do_round;    // apply one round with the current key
        logic last_round;  // skip InvMixColumns; alone, xor the round key into the state
        logic finish;      // chain the result into the output register
        logic load_chain;  // load chaining value from input
    } t_dp_cmd;

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [0:255];
        t = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
        };
        return t[x];
    endfunction

    function automatic logic [7:0] xt(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Multiplications by the fixed InvMixColumns coefficients.
    function automatic logic [7:0] mul9(input logic [7:0] a);
        return xt(xt(xt(a))) ^ a;
    endfunction
    function automatic logic [7:0] mul11(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(a) ^ a;
    endfunction
    function automatic logic [7:0] mul13(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ a;
    endfunction
    function automatic logic [7:0] mul14(input logic [7:0] a);
        return xt(xt(xt(a))) ^ xt(xt(a)) ^ xt(a);
    endfunction

endpackage
`default_nettype wire

// File: src/aes_dec_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module aes_dec_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/aes_dec_dp.sv
// Datapath: key store, shared round unit, chaining and output register.
`default_nettype none
module aes_dec_dp
    import aes_dec_pkg::*;
#(
    parameter int KEY_WORDS = KEY_WORDS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_dp_cmd                      i_cmd,
    input  wire logic                         i_key_we,
    input  wire logic [$clog2(KEY_WORDS)-1:0] i_key_waddr,
    input  wire logic [31:0]                  i_key_word,
    input  wire logic [$clog2(KEY_WORDS)-1:0] i_key_raddr,
    input  wire logic [1:0]                   i_chain_mode,
    input  wire logic [63:0]                  i_block_hi,
    input  wire logic [63:0]                  i_block_lo,
    output logic      [63:0]                  o_out_hi,
    output logic      [63:0]                  o_out_lo
);
    localparam int AW = $clog2(KEY_WORDS);

    // The store holds 4-word round keys; four RAMs give one round key per read.
    logic [31:0]  w_rk [4];
    logic [127:0] r_state;
    logic [127:0] r_ct;
    logic [127:0] r_chain;
    logic [127:0] w_round;
    logic [127:0] w_rkey;
    logic [127:0] w_plain;
    logic [127:0] w_out;

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_bank
            aes_dec_ram #(.WIDTH(32), .DEPTH(1 << (AW - 2))) u_ram (
                .i_clk  (i_clk),
                .i_we   (i_key_we && (i_key_waddr[1:0] == g[1:0])),
                .i_waddr(i_key_waddr[AW-1:2]),
                .i_wdata(i_key_word),
                .i_raddr(i_key_raddr[AW-1:2]),
                .o_rdata(w_rk[g])
            );
        end
    endgenerate

    assign w_rkey = {w_rk[0], w_rk[1], w_rk[2], w_rk[3]};

    // One round: InvShiftRows, InvSubBytes, optional InvMixColumns, AddRoundKey.
    always_comb begin
        logic [31:0] s [4];
        logic [7:0]  b [4];
        logic [7:0]  m [4];
        s[0] = r_state[127:96];
        s[1] = r_state[95:64];
        s[2] = r_state[63:32];
        s[3] = r_state[31:0];
        w_round = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                b[r] = inv_sbox(s[(c - r) & 3][8*r +: 8]);
            end
            for (int r = 0; r < 4; r++) begin
                m[r] = mul14(b[r]) ^ mul11(b[(r + 1) & 3]) ^
                       mul13(b[(r + 2) & 3]) ^ mul9(b[(r + 3) & 3]);
            end
            if (i_cmd.last_round) begin
                w_round[127 - 32*c -: 32] = {b[3], b[2], b[1], b[0]};
            end else begin
                w_round[127 - 32*c -: 32] = {m[3], m[2], m[1], m[0]};
            end
        end
        w_round = w_round ^ w_rkey;
    end

    assign w_plain = r_state ^ r_chain;
    assign w_out   = (i_chain_mode == CM_CBC || i_chain_mode == CM_PCBC) ? w_plain : r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
        end else if (i_cmd.load_chain) begin
            r_chain <= {i_block_hi, i_block_lo};
        end else if (i_cmd.finish) begin
            if (i_chain_mode == CM_CBC) begin
                r_chain <= r_ct;
            end else if (i_chain_mode == CM_PCBC) begin
                r_chain <= r_ct ^ w_plain;
            end
        end
        if (i_cmd.load_in) begin
            r_state <= {i_block_hi, i_block_lo};
            r_ct    <= {i_block_hi, i_block_lo};
        end else if (i_cmd.do_round) begin
            r_state <= (i_cmd.last_round && i_cmd.finish) ? r_state : w_round;
        end else if (i_cmd.finish == 1'b0 && i_cmd.last_round) begin
            r_state <= r_state ^ w_rkey;
        end
        if (i_cmd.finish) begin
            o_out_hi <= w_out[127:64];
            o_out_lo <= w_out[63:0];
        end
    end
endmodule
`default_nettype wire

// File: src/aes_dec_ctrl.sv
// Controller: sequences key reads and rounds for each decrypt transfer.
`default_nettype none
module aes_dec_ctrl
    import aes_dec_pkg::*;
#(
    parameter int KEY_WORDS = KEY_WORDS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_fire,
    input  wire logic [1:0]                   i_op,
    input  wire logic [1:0]                   i_key_size_mode,
    input  wire logic                         i_out_ready,
    output logic                              o_in_ready,
    output logic                              o_out_valid,
    output t_dp_cmd                           o_cmd,
    output logic [$clog2(KEY_WORDS)-1:0]      o_key_raddr
);
    localparam int AW = $clog2(KEY_WORDS);

    typedef enum logic [1:0] {S_IDLE, S_WHITEN, S_ROUND, S_DONE} t_state;

    t_state     r_state;
    logic [3:0] r_rnd;
    logic [3:0] w_nr;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_done_go;

    assign w_nr = (i_key_size_mode == KS_128) ? 4'd10 :
                  (i_key_size_mode == KS_192) ? 4'd12 : 4'd14;

    // The last step waits while the result register still holds an untaken result.
    assign w_done_go   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_done_go) begin
            n_out_valid = 1'b1;
        end
    end

    // Key RAM address is presented in the state before the one that uses the key (registered read).
    always_comb begin
        o_key_raddr = '0;
        unique case (r_state)
            S_IDLE:   o_key_raddr = '0;
            S_WHITEN: o_key_raddr = AW'({r_rnd + 4'd1, 2'b00});
            S_ROUND:  o_key_raddr = AW'({r_rnd + 4'd1, 2'b00});
            S_DONE:   o_key_raddr = '0;
            default:  o_key_raddr = '0;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.load_in    = i_in_fire && (i_op == OP_DECRYPT);
        o_cmd.load_chain = i_in_fire && (i_op == OP_LOAD_CHAIN);
        unique case (r_state)
            S_WHITEN: o_cmd.last_round = 1'b1;
            S_ROUND: begin
                o_cmd.do_round   = 1'b1;
                o_cmd.last_round = (r_rnd == w_nr);
            end
            S_DONE:  o_cmd.finish = w_done_go;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rnd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_fire && i_op == OP_DECRYPT) begin
                        r_state <= S_WHITEN;
                        r_rnd   <= '0;
                    end
                end
                S_WHITEN: begin
                    r_state <= S_ROUND;
                    r_rnd   <= 4'd1;
                end
                S_ROUND: begin
                    if (r_rnd == w_nr) begin
                        r_state <= S_DONE;
                    end
                    r_rnd <= r_rnd + 4'd1;
                end
                S_DONE: begin
                    if (w_done_go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: src/aes_block_decrypt_chained.sv
// Top level of the chained AES block decryptor.
// AES decryptor in equivalent-inverse-cipher form with ECB, CBC or PCBC chaining.
// One input transfer either loads a round-key word (op 0, decryption schedule
// order, index beyond the store ignored), loads the 128-bit chaining value
// (op 1) or decrypts one block (op 2); only op 2 yields an output transfer.
// A decrypt proceeds in order: the cycle of its transfer presents the
// whitening-key address to the round-key RAM, state S_WHITEN applies that key,
// state S_ROUND runs the Nr rounds through the single shared round unit, and
// state S_DONE chains the block and registers the result; Nr is 10, 12 or 14
// from key_size_mode. The key store is four banks of RAM so that one whole
// round key is read per cycle. The next transfer is taken as soon as the
// controller is idle, even while the previous result still waits; a decrypt
// taken then holds in its last step until that result has been transferred
// out. The user must write configuration only while idle; the block itself
// does not enforce it.
`default_nettype none
module aes_block_decrypt_chained
    import aes_dec_pkg::*;
#(
    parameter int KEY_WORDS = KEY_WORDS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_op,
    input  wire logic [5:0]  i_key_index,
    input  wire logic [31:0] i_key_word,
    input  wire logic [63:0] i_block_hi,
    input  wire logic [63:0] i_block_lo,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [63:0]      o_out_hi,
    output logic [63:0]      o_out_lo,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [1:0]  i_cfg_data
);
    localparam int AW = $clog2(KEY_WORDS);

    logic          w_in_fire;
    logic          w_key_we;
    logic [AW-1:0] w_key_raddr;
    t_dp_cmd       w_cmd;
    logic [1:0]    r_key_size_mode;
    logic [1:0]    r_chain_mode;

    assign w_in_fire   = i_valid && o_ready;
    // Writes past the store's end are dropped.
    assign w_key_we    = w_in_fire && (i_op == OP_LOAD_KEY) &&
                         (7'(i_key_index) < 7'(KEY_WORDS));
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_size_mode <= KS_128;
            r_chain_mode    <= CM_ECB;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_KEY_SIZE: r_key_size_mode <= i_cfg_data;
                CFG_CHAIN:    r_chain_mode    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aes_dec_ctrl #(.KEY_WORDS(KEY_WORDS)) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_fire      (w_in_fire),
        .i_op           (i_op),
        .i_key_size_mode(r_key_size_mode),
        .i_out_ready    (i_ready),
        .o_in_ready     (o_ready),
        .o_out_valid    (o_valid),
        .o_cmd          (w_cmd),
        .o_key_raddr    (w_key_raddr)
    );

    aes_dec_dp #(.KEY_WORDS(KEY_WORDS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_key_we    (w_key_we),
        .i_key_waddr (i_key_index[AW-1:0]),
        .i_key_word  (i_key_word),
        .i_key_raddr (w_key_raddr),
        .i_chain_mode(r_chain_mode),
        .i_block_hi  (i_block_hi),
        .i_block_lo  (i_block_lo),
        .o_out_hi    (o_out_hi),
        .o_out_lo    (o_out_lo)
    );

    // A pending result stays put, payload unchanged, until it is transferred.
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_hi) && $stable(o_out_lo))
        else $error("pending result dropped or changed");

    // The datapath never gets a round and a block load in the same cycle.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load_in && w_cmd.do_round)) else $error("load during round");

    // A result becomes valid only in the cycle after a finish command.
    a_finish_then_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_cmd.finish)) else $error("result without finish");
endmodule
`default_nettype wire

// File: test/aes_block_decrypt_chained_tb.sv
// Testbench for the chained AES block decryptor, checked against a behavioral predictor.
`timescale 1ns / 1ps
`default_nettype none
module aes_block_decrypt_chained_tb;
    import aes_dec_pkg::*;

    localparam int STORE_WORDS = 60;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_op;
    logic [5:0]  i_key_index;
    logic [31:0] i_key_word;
    logic [63:0] i_block_hi;
    logic [63:0] i_block_lo;
    logic        o_valid;
    logic        i_ready;
    logic [63:0] o_out_hi;
    logic [63:0] o_out_lo;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index;
    logic [1:0]  i_cfg_data;

    aes_block_decrypt_chained uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_op(i_op),
        .i_key_index(i_key_index), .i_key_word(i_key_word),
        .i_block_hi(i_block_hi), .i_block_lo(i_block_lo),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_out_hi(o_out_hi), .o_out_lo(o_out_lo),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: its own copy of the key store, chain and registers.
    logic [31:0]  rk_words [STORE_WORDS];
    logic [63:0]  chain_h, chain_l;
    logic [1:0]   ks_mode, ch_mode;
    logic [127:0] plaintext_q [$];
    int           mismatches;
    bit           calm;        // When set, neither side idles.

    // Table of the inverse S-box, built from the GF(2^8) inverse.
    logic [7:0] inv_sub [256];

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic void build_inv_sub();
        logic [7:0] inv, p, s;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            if (x != 0) begin
                p = 8'h01;
                for (int k = 0; k < 254; k++) p = gf_mul(p, x[7:0]);
                inv = p;
            end
            s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
            inv_sub[s] = x[7:0];
        end
    endfunction

    // Equivalent inverse cipher on four little-endian packed words.
    function automatic logic [127:0] inverse_cipher(input logic [127:0] blk);
        logic [31:0] s [4];
        logic [31:0] t [4];
        logic [7:0]  b [4];
        logic [7:0]  m [4];
        int nr;
        nr = (ks_mode == KS_128) ? 10 : (ks_mode == KS_192) ? 12 : 14;
        for (int c = 0; c < 4; c++) s[c] = blk[127 - 32*c -: 32] ^ rk_words[c];
        for (int rnd = 1; rnd <= nr; rnd++) begin
            for (int c = 0; c < 4; c++) begin
                for (int r = 0; r < 4; r++) b[r] = inv_sub[s[(c - r) & 3][8*r +: 8]];
                if (rnd < nr) begin
                    for (int r = 0; r < 4; r++)
                        m[r] = gf_mul(b[r], 8'h0e) ^ gf_mul(b[(r+1)&3], 8'h0b)
                             ^ gf_mul(b[(r+2)&3], 8'h0d) ^ gf_mul(b[(r+3)&3], 8'h09);
                    b = m;
                end
                t[c] = {b[3], b[2], b[1], b[0]} ^ rk_words[4*rnd + c];
            end
            s = t;
        end
        return {s[0], s[1], s[2], s[3]};
    endfunction

    // Applies one accepted item to the predictor and queues any plaintext.
    function automatic void predict_item(input logic [1:0] op, input logic [5:0] idx,
                                         input logic [31:0] kw, input logic [63:0] hi,
                                         input logic [63:0] lo);
        logic [127:0] pt;
        case (op)
            OP_LOAD_KEY: begin
                if (idx < STORE_WORDS) rk_words[idx] = kw;
            end
            OP_LOAD_CHAIN: begin
                chain_h = hi;
                chain_l = lo;
            end
            OP_DECRYPT: begin
                pt = inverse_cipher({hi, lo});
                if (ch_mode == CM_CBC) begin
                    pt ^= {chain_h, chain_l};
                    {chain_h, chain_l} = {hi, lo};
                end else if (ch_mode == CM_PCBC) begin
                    pt ^= {chain_h, chain_l};
                    {chain_h, chain_l} = {hi, lo} ^ pt;
                end
                plaintext_q.push_back(pt);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // Output side: random stall, and a check of every result transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (plaintext_q.size() == 0) begin
                    report_mismatch("unexpected result hi", o_out_hi, 64'h0);
                end else begin
                    if (o_out_hi !== plaintext_q[0][127:64])
                        report_mismatch("out_hi", o_out_hi, plaintext_q[0][127:64]);
                    if (o_out_lo !== plaintext_q[0][63:0])
                        report_mismatch("out_lo", o_out_lo, plaintext_q[0][63:0]);
                    void'(plaintext_q.pop_front());
                end
            end
            i_ready <= calm || ($urandom_range(99) >= 21);
        end
    end

    // Sends one item, holding it until the transfer happens; valid is left to
    // the next idle cycle or the next item.
    task automatic send_item(input logic [1:0] op, input logic [5:0] idx,
                             input logic [31:0] kw, input logic [63:0] hi,
                             input logic [63:0] lo);
        while (!calm && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_op        <= op;
        i_key_index <= idx;
        i_key_word  <= kw;
        i_block_hi  <= hi;
        i_block_lo  <= lo;
        do @(posedge i_clk); while (!(o_ready === 1'b1));
        predict_item(op, idx, kw, hi, lo);
    endtask

    // Waits for outstanding results, then lets the block settle.
    task automatic drain();
        i_valid <= 1'b0;
        while (plaintext_q.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [1:0] val);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!(o_cfg_ready === 1'b1));
        i_cfg_valid <= 1'b0;
        if (idx == CFG_KEY_SIZE) ks_mode = val;
        else ch_mode = val;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Fills the whole store so no decrypt ever reads an unwritten word.
    task automatic load_schedule();
        for (int i = 0; i < STORE_WORDS; i++) send_item(OP_LOAD_KEY, i[5:0], $urandom, 0, 0);
    endtask

    task automatic test_directed();
        load_schedule();
        send_item(OP_LOAD_KEY, 6'd0, 32'h0000_0000, 0, 0);
        send_item(OP_LOAD_KEY, 6'd59, 32'hffff_ffff, 0, 0);
        // Out-of-range indexes are ignored by the block.
        send_item(OP_LOAD_KEY, 6'd60, 32'hdead_beef, 0, 0);
        send_item(OP_LOAD_KEY, 6'd63, 32'h1234_5678, 0, 0);
        send_item(OP_DECRYPT, 0, 0, 64'h0, 64'h0);
        send_item(OP_DECRYPT, 0, 0, '1, '1);
        send_item(OP_DECRYPT, 6'h3f, '1, 64'haaaa_aaaa_5555_5555, 64'h0123_4567_89ab_cdef);
        // Op three is ignored: no result, no state change.
        send_item(OP_UNUSED, 6'h15, 32'hcafe_f00d, '1, '1);
        send_item(OP_LOAD_CHAIN, 0, 0, '1, 64'h0);
        send_item(OP_DECRYPT, 0, 0, 64'h5555_5555_aaaa_aaaa, '1);
    endtask

    // Random mix: mostly decrypts, some chain reloads and key rewrites, and occasional unused ops.
    task automatic test_random(input int count);
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_item(OP_DECRYPT, 6'($urandom), $urandom, rand64(), rand64());
            else if (pick < 80)
                send_item(OP_LOAD_CHAIN, 6'($urandom), $urandom, rand64(), rand64());
            else if (pick < 95)
                send_item(OP_LOAD_KEY, 6'($urandom_range(63)), $urandom, rand64(), rand64());
            else
                send_item(OP_UNUSED, 6'($urandom), $urandom, rand64(), rand64());
        end
    endtask

    // Sweeps every key size and chain mode, the unused codes included.
    task automatic test_modes();
        for (int ks = 0; ks < 4; ks++) begin
            for (int cm = 0; cm < 4; cm++) begin
                write_reg(CFG_KEY_SIZE, ks[1:0]);
                write_reg(CFG_CHAIN, cm[1:0]);
                calm = (ks == 2 && cm == 1);
                test_random(50);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_clk = 1'b0;
        i_valid = 1'b0;
        i_op = OP_LOAD_KEY;
        i_key_index = '0;
        i_key_word = '0;
        i_block_hi = '0;
        i_block_lo = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_KEY_SIZE;
        i_cfg_data = '0;
        calm = 1'b0;
        mismatches = 0;
        chain_h = '0;
        chain_l = '0;
        ks_mode = KS_128;
        ch_mode = CM_ECB;
        foreach (rk_words[i]) rk_words[i] = '0;
        build_inv_sub();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_reg(CFG_CHAIN, CM_CBC);
        test_directed();
        write_reg(CFG_CHAIN, CM_PCBC);
        write_reg(CFG_KEY_SIZE, 2'd2);
        test_directed();
        test_modes();
        drain();

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
`default_nettype wire

// File: aes_block_decrypt_chained.f
src/aes_dec_pkg.sv
src/aes_dec_ram.sv
src/aes_dec_dp.sv
src/aes_dec_ctrl.sv
src/aes_block_decrypt_chained.sv
test/aes_block_decrypt_chained_tb.sv
